FILE: hw/rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg: shared types and constants for thermal_raw_to_celsius
// Register map codes, field widths, fixed-point constants and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

    // Field widths
    localparam int RAW_W        = 16;
    localparam int RAW_BITS_DEF = 16;
    localparam int TEMP_W       = 16;

    // Register widths
    localparam int GAIN_W = 24;
    localparam int OFFS_W = 28;
    localparam int R1_W   = 32;
    localparam int R2_W   = 32;
    localparam int B_W    = 24;
    localparam int F_W    = 20;
    localparam int O_W    = 24;

    // APB
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Datapath widths
    localparam int S8_W       = 31;   // signed radiance sum
    localparam int MAG_W      = 30;   // |s8|
    localparam int D_W        = 62;   // r2 * |s8|
    localparam int Q1_W       = 62;   // clamped quotient
    localparam int DIV1_STEPS = 80;
    localparam int NUM1_SHIFT = 48;
    localparam int A_W        = 63;   // log argument magnitude
    localparam int LZ_W       = 6;
    localparam int X_W        = 32;   // Q1.31 mantissa
    localparam int FRAC_W     = 30;
    localparam int LN_W       = 38;
    localparam int LNM_W      = 36;
    localparam int Q2_W       = 62;
    localparam int DIV2_STEPS = 62;
    localparam int NUM2_SHIFT = 38;

    localparam logic [23:0] LN2_Q24    = 24'd11629080;
    localparam logic [24:0] KELVIN_Q16 = 25'd17901158;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST = 24'd1048576;
    localparam logic [OFFS_W-1:0] OFFS_RST = 28'd0;
    localparam logic [R1_W-1:0]   R1_RST   = 32'd5403333;
    localparam logic [R2_W-1:0]   R2_RST   = 32'd53880795;
    localparam logic [B_W-1:0]    B_RST    = 24'd384256;
    localparam logic [F_W-1:0]    F_RST    = 20'd65536;
    localparam logic [O_W-1:0]    O_RST    = 24'hE35400;   // -1879040

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_GAIN = 3'd0,
        REG_OFFS = 3'd1,
        REG_R1   = 3'd2,
        REG_R2   = 3'd3,
        REG_B    = 3'd4,
        REG_F    = 3'd5,
        REG_O    = 3'd6
    } reg_idx_t;

    // Forced result of an item
    typedef enum logic [1:0] {
        SPEC_NONE = 2'd0,
        SPEC_MIN  = 2'd1,
        SPEC_MAX  = 2'd2
    } spec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/trc_div_cell.sv
// ----------------------------------------------------------------------------
// trc_div_cell: one restoring-division step
// Shifts one numerator bit into the remainder, produces one quotient bit and
// keeps a sticky overflow bit for quotients beyond QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_div_cell #(
    parameter int DW = 62,
    parameter int QW = 62,
    parameter int PW = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic          num_bit,
    input  wire logic [DW-1:0] in_rem,
    input  wire logic [DW-1:0] in_div,
    input  wire logic [QW-1:0] in_quo,
    input  wire logic          in_sat,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [DW-1:0]      out_rem,
    output logic [DW-1:0]      out_div,
    output logic [QW-1:0]      out_quo,
    output logic               out_sat,
    output logic [PW-1:0]      out_pay
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg;
    logic [QW-1:0] quo_reg, quo_next;
    logic          sat_reg, sat_next;
    logic [PW-1:0] pay_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // Trial subtract
    always_comb begin
        trial    = {in_rem, num_bit};
        diff     = trial - {1'b0, in_div};
        ge       = (trial >= {1'b0, in_div});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {in_quo[QW-2:0], ge};
        sat_next = in_sat | in_quo[QW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            div_reg <= in_div;
            quo_reg <= quo_next;
            sat_reg <= sat_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quo   = quo_reg;
    assign out_sat   = sat_reg;
    assign out_pay   = pay_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/trc_norm_cell.sv
// ----------------------------------------------------------------------------
// trc_norm_cell: one step of the leading-zero normalizer
// Shifts left by SH when the top SH bits are all zero and counts the shift.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_norm_cell
    import trc_pkg::*;
#(
    parameter int SH = 32,
    parameter int PW = 3
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [A_W-1:0]   in_val,
    input  wire logic [LZ_W-1:0]  in_lz,
    input  wire logic [PW-1:0]    in_pay,
    output logic                  out_valid,
    output logic [A_W-1:0]        out_val,
    output logic [LZ_W-1:0]       out_lz,
    output logic [PW-1:0]         out_pay
);

    logic            valid_reg;
    logic [A_W-1:0]  val_reg, val_next;
    logic [LZ_W-1:0] lz_reg, lz_next;
    logic [PW-1:0]   pay_reg;

    // Conditional shift
    always_comb begin
        if (in_val[A_W-1 -: SH] == '0) begin
            val_next = in_val << SH;
            lz_next  = in_lz + LZ_W'(SH);
        end else begin
            val_next = in_val;
            lz_next  = in_lz;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= val_next;
            lz_reg  <= lz_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_val   = val_reg;
    assign out_lz    = lz_reg;
    assign out_pay   = pay_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/trc_sq_cell.sv
// ----------------------------------------------------------------------------
// trc_sq_cell: one bit of the log2 fraction by squaring
// Squares the Q1.31 mantissa, renormalizes and sets fraction bit FB when
// the square reached two.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_sq_cell
    import trc_pkg::*;
#(
    parameter int FB = 29,
    parameter int PW = 9
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [X_W-1:0]    in_x,
    input  wire logic [FRAC_W-1:0] in_frac,
    input  wire logic [PW-1:0]     in_pay,
    output logic                   out_valid,
    output logic [X_W-1:0]         out_x,
    output logic [FRAC_W-1:0]      out_frac,
    output logic [PW-1:0]          out_pay
);

    logic              valid_reg;
    logic [X_W-1:0]    x_reg, x_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [PW-1:0]     pay_reg;
    logic [2*X_W-1:0]  prod;
    logic [X_W:0]      y;

    // Square and renormalize
    always_comb begin
        prod      = in_x * in_x;
        y         = prod[2*X_W-1:X_W-1];
        frac_next = in_frac;
        if (y[X_W]) begin
            x_next        = y[X_W:1];
            frac_next[FB] = 1'b1;
        end else begin
            x_next = y[X_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            frac_reg <= frac_next;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_frac  = frac_reg;
    assign out_pay   = pay_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/thermal_raw_to_celsius.sv
// ----------------------------------------------------------------------------
// thermal_raw_to_celsius: radiometric count to temperature (Planck inverse)
//
//   channel   dir  handshake               payload
//   s_*       in   s_tvalid / s_tready     s_tdata = raw_count
//   m_*       out  m_tvalid / m_tready     m_tdata = temperature,
//                                          m_tuser = out_of_range
//   apb       in   psel/penable/pready     7 registers at 4*index
//
// One pixel per clock unless the pipeline holds. It has 3 front stages, 80 divider
// cells, 1 argument stage, 6 normalizer cells, 30 squaring cells, 2 log
// scaling stages, 62 divider cells and the output register.
// The whole pipeline advances together; it holds when a result waits and
// m_tready is low. Reset clears the valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_raw_to_celsius
    import trc_pkg::*;
#(
    parameter int RAW_BITS = RAW_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input requests
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [RAW_W-1:0]  s_tdata,   // [15:0] raw_count
    // results
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [TEMP_W-1:0]      m_tdata,   // [15:0] temperature
    output logic [0:0]             m_tuser,   // [0] out_of_range
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int PROD_W = RAW_BITS + GAIN_W;
    localparam int OBJ_W  = RAW_BITS + GAIN_W - 11;
    localparam int P1_W   = 2;                 // {pos, zero}
    localparam int P2_W   = 3;                 // {spec, flag}
    localparam int P3_W   = 3 + LZ_W;          // {spec, flag, p}
    localparam int P4_W   = 4;                 // {spec, flag, neg}

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] gain_reg;
    logic [OFFS_W-1:0] offs_reg;
    logic [R1_W-1:0]   r1_reg;
    logic [R2_W-1:0]   r2_reg;
    logic [B_W-1:0]    b_reg;
    logic [F_W-1:0]    f_reg;
    logic [O_W-1:0]    o_reg;
    reg_idx_t          reg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RST;
            offs_reg <= OFFS_RST;
            r1_reg   <= R1_RST;
            r2_reg   <= R2_RST;
            b_reg    <= B_RST;
            f_reg    <= F_RST;
            o_reg    <= O_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GAIN: gain_reg <= pwdata[GAIN_W-1:0];
                REG_OFFS: offs_reg <= pwdata[OFFS_W-1:0];
                REG_R1:   r1_reg   <= pwdata[R1_W-1:0];
                REG_R2:   r2_reg   <= pwdata[R2_W-1:0];
                REG_B:    b_reg    <= pwdata[B_W-1:0];
                REG_F:    f_reg    <= pwdata[F_W-1:0];
                REG_O:    o_reg    <= pwdata[O_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_GAIN: prdata = DATA_W'(gain_reg);
            REG_OFFS: prdata = DATA_W'(offs_reg);
            REG_R1:   prdata = DATA_W'(r1_reg);
            REG_R2:   prdata = DATA_W'(r2_reg);
            REG_B:    prdata = DATA_W'(b_reg);
            REG_F:    prdata = DATA_W'(f_reg);
            REG_O:    prdata = DATA_W'(o_reg);
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance
    // ------------------------------------------------------------------
    logic adv;
    logic m_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Front: obj8, s8, denominator
    // ------------------------------------------------------------------
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [OBJ_W-1:0]  obj_reg, obj_next;
    logic [PROD_W-1:0] prod1;
    logic [PROD_W:0]   sum1;
    logic [S8_W-1:0]   obj_ext;
    logic signed [S8_W-1:0] s8;
    logic [S8_W-1:0]   s8_abs;
    logic [MAG_W-1:0]  mag_reg;
    logic              pos_reg;
    logic [D_W-1:0]    d_reg;
    logic              zero_reg;
    logic              pos3_reg;

    always_comb begin
        prod1    = s_tdata[RAW_BITS-1:0] * gain_reg;
        sum1     = (PROD_W + 1)'(prod1) + (PROD_W + 1)'(2048);
        obj_next = sum1[PROD_W:12];
        obj_ext  = S8_W'(obj_reg);
        s8       = $signed(obj_ext) - S8_W'($signed(offs_reg)) + S8_W'($signed(o_reg));
        s8_abs   = s8[S8_W-1] ? S8_W'(-s8) : S8_W'(s8);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            obj_reg  <= obj_next;
            mag_reg  <= s8_abs[MAG_W-1:0];
            pos_reg  <= !s8[S8_W-1] && (s8 != '0);
            d_reg    <= r2_reg * mag_reg;
            zero_reg <= (r2_reg == '0) || (mag_reg == '0);
            pos3_reg <= pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider 1: q = r1 * 2^48 / D
    // ------------------------------------------------------------------
    logic            d1_valid [0:DIV1_STEPS];
    logic [D_W-1:0]  d1_rem   [0:DIV1_STEPS];
    logic [D_W-1:0]  d1_div   [0:DIV1_STEPS];
    logic [Q1_W-1:0] d1_quo   [0:DIV1_STEPS];
    logic            d1_sat   [0:DIV1_STEPS];
    logic [P1_W-1:0] d1_pay   [0:DIV1_STEPS];

    assign d1_valid[0] = s3_valid_reg;
    assign d1_rem[0]   = '0;
    assign d1_div[0]   = d_reg;
    assign d1_quo[0]   = '0;
    assign d1_sat[0]   = 1'b0;
    assign d1_pay[0]   = {pos3_reg, zero_reg};

    for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
        localparam int BI = DIV1_STEPS - 1 - k;
        logic nb;
        if (BI >= NUM1_SHIFT) begin : g_nb
            assign nb = r1_reg[BI-NUM1_SHIFT];
        end else begin : g_nz
            assign nb = 1'b0;
        end
        trc_div_cell #(.DW(D_W), .QW(Q1_W), .PW(P1_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(d1_valid[k]), .num_bit(nb),
            .in_rem(d1_rem[k]), .in_div(d1_div[k]), .in_quo(d1_quo[k]),
            .in_sat(d1_sat[k]), .in_pay(d1_pay[k]),
            .out_valid(d1_valid[k+1]), .out_rem(d1_rem[k+1]),
            .out_div(d1_div[k+1]), .out_quo(d1_quo[k+1]),
            .out_sat(d1_sat[k+1]), .out_pay(d1_pay[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Log argument a = F +/- q
    // ------------------------------------------------------------------
    logic [Q1_W-1:0]   q1;
    logic signed [63:0] a_s;
    logic              a_bad;
    logic              s4_valid_reg;
    logic [A_W-1:0]    a_reg;
    logic [P2_W-1:0]   s4_pay_reg;
    spec_t             spec4;

    always_comb begin
        q1    = d1_sat[DIV1_STEPS] ? '1 : d1_quo[DIV1_STEPS];
        if (d1_pay[DIV1_STEPS][1]) begin
            a_s = $signed(64'(q1)) + $signed(64'(f_reg));
        end else begin
            a_s = $signed(64'(f_reg)) - $signed(64'(q1));
        end
        a_bad = d1_pay[DIV1_STEPS][0] || a_s[63] || (a_s == '0);
        spec4 = a_bad ? SPEC_MIN : SPEC_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= d1_valid[DIV1_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg      <= a_bad ? A_W'(1) : a_s[A_W-1:0];
            s4_pay_reg <= {spec4, a_bad | d1_sat[DIV1_STEPS]};
        end
    end

    // ------------------------------------------------------------------
    // Normalizer: msb position of a
    // ------------------------------------------------------------------
    logic            n_valid [0:6];
    logic [A_W-1:0]  n_val   [0:6];
    logic [LZ_W-1:0] n_lz    [0:6];
    logic [P2_W-1:0] n_pay   [0:6];

    assign n_valid[0] = s4_valid_reg;
    assign n_val[0]   = a_reg;
    assign n_lz[0]    = '0;
    assign n_pay[0]   = s4_pay_reg;

    for (genvar k = 0; k < 6; k++) begin : g_norm
        trc_norm_cell #(.SH(32 >> k), .PW(P2_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(n_valid[k]), .in_val(n_val[k]), .in_lz(n_lz[k]),
            .in_pay(n_pay[k]),
            .out_valid(n_valid[k+1]), .out_val(n_val[k+1]), .out_lz(n_lz[k+1]),
            .out_pay(n_pay[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Squaring chain: log2 fraction
    // ------------------------------------------------------------------
    logic              q_valid [0:FRAC_W];
    logic [X_W-1:0]    q_x     [0:FRAC_W];
    logic [FRAC_W-1:0] q_frac  [0:FRAC_W];
    logic [P3_W-1:0]   q_pay   [0:FRAC_W];
    logic [LZ_W-1:0]   msb_pos;

    assign msb_pos    = LZ_W'(A_W - 1) - n_lz[6];
    assign q_valid[0] = n_valid[6];
    assign q_x[0]     = n_val[6][A_W-1 -: X_W];
    assign q_frac[0]  = '0;
    assign q_pay[0]   = {n_pay[6], msb_pos};

    for (genvar k = 0; k < FRAC_W; k++) begin : g_sq
        trc_sq_cell #(.FB(FRAC_W - 1 - k), .PW(P3_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(q_valid[k]), .in_x(q_x[k]), .in_frac(q_frac[k]),
            .in_pay(q_pay[k]),
            .out_valid(q_valid[k+1]), .out_x(q_x[k+1]), .out_frac(q_frac[k+1]),
            .out_pay(q_pay[k+1])
        );
    end

    // ------------------------------------------------------------------
    // ln = log2 * ln2, in two partial products
    // ------------------------------------------------------------------
    logic signed [LZ_W:0] p_off;
    logic                 s5_valid_reg, s6_valid_reg;
    logic signed [31:0]   pm_reg;
    logic [53:0]          fm_reg;
    logic [P2_W-1:0]      s5_pay_reg;
    logic signed [63:0]   ln_sum;
    logic signed [LN_W-1:0] ln_val;
    logic [LN_W-1:0]      ln_abs;
    spec_t                spec5, spec6;
    logic                 ln_zero;
    logic [LNM_W-1:0]     lnm_reg;
    logic [P4_W-1:0]      s6_pay_reg;

    assign p_off = $signed({1'b0, q_pay[FRAC_W][LZ_W-1:0]}) - (LZ_W + 1)'(16);

    always_comb begin
        ln_sum  = (64'(pm_reg) <<< 30) + $signed(64'(fm_reg)) + 64'sd8388608;
        ln_val  = ln_sum[LN_W+23:24];
        ln_abs  = ln_val[LN_W-1] ? LN_W'(-ln_val) : LN_W'(ln_val);
        ln_zero = (ln_val == '0);
        spec5   = spec_t'(s5_pay_reg[P2_W-1:1]);
        spec6   = spec5;
        if (spec5 == SPEC_NONE && ln_zero) begin
            spec6 = SPEC_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (adv) begin
            s5_valid_reg <= q_valid[FRAC_W];
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pm_reg     <= 32'(p_off) * $signed({8'd0, LN2_Q24});
            fm_reg     <= q_frac[FRAC_W] * LN2_Q24;
            s5_pay_reg <= q_pay[FRAC_W][P3_W-1:LZ_W];
            lnm_reg    <= ln_zero ? LNM_W'(1) : ln_abs[LNM_W-1:0];
            s6_pay_reg <= {spec6, s5_pay_reg[0] | ln_zero, ln_val[LN_W-1]};
        end
    end

    // ------------------------------------------------------------------
    // Divider 2: T16 = B * 2^38 / |ln|
    // ------------------------------------------------------------------
    logic             e_valid [0:DIV2_STEPS];
    logic [LNM_W-1:0] e_rem   [0:DIV2_STEPS];
    logic [LNM_W-1:0] e_div   [0:DIV2_STEPS];
    logic [Q2_W-1:0]  e_quo   [0:DIV2_STEPS];
    logic             e_sat   [0:DIV2_STEPS];
    logic [P4_W-1:0]  e_pay   [0:DIV2_STEPS];

    assign e_valid[0] = s6_valid_reg;
    assign e_rem[0]   = '0;
    assign e_div[0]   = lnm_reg;
    assign e_quo[0]   = '0;
    assign e_sat[0]   = 1'b0;
    assign e_pay[0]   = s6_pay_reg;

    for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
        localparam int BI = DIV2_STEPS - 1 - k;
        logic nb;
        if (BI >= NUM2_SHIFT) begin : g_nb
            assign nb = b_reg[BI-NUM2_SHIFT];
        end else begin : g_nz
            assign nb = 1'b0;
        end
        trc_div_cell #(.DW(LNM_W), .QW(Q2_W), .PW(P4_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(e_valid[k]), .num_bit(nb),
            .in_rem(e_rem[k]), .in_div(e_div[k]), .in_quo(e_quo[k]),
            .in_sat(e_sat[k]), .in_pay(e_pay[k]),
            .out_valid(e_valid[k+1]), .out_rem(e_rem[k+1]),
            .out_div(e_div[k+1]), .out_quo(e_quo[k+1]),
            .out_sat(e_sat[k+1]), .out_pay(e_pay[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Kelvin to Celsius, rounding, saturation, output register
    // ------------------------------------------------------------------
    logic signed [63:0] t16;
    logic signed [63:0] t_round;
    logic signed [63:0] t_cel;
    logic [TEMP_W-1:0]  temp_next;
    logic               flag_next;
    spec_t              spec7;
    logic [TEMP_W-1:0]  m_data_reg;
    logic               m_user_reg;

    always_comb begin
        t16       = e_pay[DIV2_STEPS][0] ? -$signed(64'(e_quo[DIV2_STEPS]))
                                         : $signed(64'(e_quo[DIV2_STEPS]));
        t_round   = t16 - $signed(64'(KELVIN_Q16)) + 64'sd2048;
        t_cel     = t_round >>> 12;
        spec7     = spec_t'(e_pay[DIV2_STEPS][P4_W-1:2]);
        flag_next = e_pay[DIV2_STEPS][1];
        unique case (spec7)
            SPEC_MIN: temp_next = 16'h8000;
            SPEC_MAX: temp_next = 16'h7FFF;
            SPEC_NONE: begin
                if (t_cel > 64'sd32767) begin
                    temp_next = 16'h7FFF;
                    flag_next = 1'b1;
                end else if (t_cel < -64'sd32768) begin
                    temp_next = 16'h8000;
                    flag_next = 1'b1;
                end else begin
                    temp_next = t_cel[TEMP_W-1:0];
                end
            end
            default: temp_next = 16'h8000;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= e_valid[DIV2_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= temp_next;
            m_user_reg <= flag_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

`default_nettype wire
